// File: rtl/epsm_pkg.sv
// shared types and constants of the encoder period speed meter
package epsm_pkg;

  // stream payload widths (fields packed from bit 0, padded to whole bytes)
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 104;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT = 2'd0,
    REG_PPR     = 2'd1,
    REG_RADIUS  = 2'd2
  } epsm_reg_t;

  localparam int TIMEOUT_W = 20;
  localparam int PPR_W     = 20;
  localparam int RADIUS_W  = 12;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd10000;
  localparam logic [PPR_W-1:0]     PPR_RST     = 20'd45174;
  localparam logic [RADIUS_W-1:0]  RADIUS_RST  = 12'd40;

  // period and divider widths
  localparam int PERIOD_W = 32;
  localparam int DEN_W    = PERIOD_W + PPR_W;
  localparam int NUM_W    = DEN_W + 1;
  localparam int QUOT_W   = 31;
  localparam int CNT_W    = 5;
  localparam int SPEED_W  = 32;

  // numerators: 1e8 * 2^16, and pi * 2^30 * 1e8 shifted for angular and linear
  localparam logic [63:0]      PI_E8   = 64'd3373259426 * 64'd100000000;
  localparam logic [NUM_W-1:0] RPS_NUM = NUM_W'(64'd100000000 << 16);
  localparam logic [NUM_W-1:0] ANG_NUM = NUM_W'(PI_E8 >> 13);
  localparam logic [NUM_W-1:0] VEL_NUM = NUM_W'(PI_E8 >> 21);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ELAPSED,
    ST_CHECK,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_OUT_STOP,
    ST_OUT_SPEED
  } epsm_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_item;
    logic load_elapsed;
    logic write_edge;
    logic load_period;
    logic load_operands;
    logic div_start;
    logic load_result;
    logic result_stopped;
  } epsm_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic chan_ok;
    logic is_sample;
    logic timed_out;
    logic div_busy;
  } epsm_stat_t;

endpackage

// File: rtl/epsm_div.sv
// iterative restoring divider, rounded and saturated 31-bit quotient
module epsm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [epsm_pkg::NUM_W-1:0] num,
  input  logic [epsm_pkg::DEN_W-1:0] den,
  output logic                       busy,
  output logic [epsm_pkg::QUOT_W-1:0] mag
);
  import epsm_pkg::*;

  localparam int REM_W = DEN_W + 1;

  logic [NUM_W-1:0]  num_rnd;
  logic              sat_next;
  logic [REM_W-1:0]  rem_sh;
  logic              fits;
  logic [REM_W-1:0]  rem;
  logic [QUOT_W-1:0] low;
  logic [QUOT_W-1:0] quo;
  logic [CNT_W-1:0]  cnt;
  logic              sat;

  // round half up, saturate when the quotient would not fit in 31 bits
  assign num_rnd  = num + NUM_W'(den >> 1);
  assign sat_next = (den == '0) || (DEN_W'(num_rnd >> QUOT_W) >= den);

  // one quotient bit per step
  assign rem_sh = {rem[REM_W-2:0], low[QUOT_W-1]};
  assign fits   = rem_sh >= REM_W'(den);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(QUOT_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= REM_W'(num_rnd >> QUOT_W);
      low <= num_rnd[QUOT_W-1:0];
      quo <= '0;
      sat <= sat_next;
    end else if (busy) begin
      rem <= fits ? (rem_sh - REM_W'(den)) : rem_sh;
      low <= {low[QUOT_W-2:0], 1'b0};
      quo <= {quo[QUOT_W-2:0], fits};
    end
  end

  assign mag = sat ? '1 : quo;

endmodule

// File: rtl/epsm_datapath.sv
// channel state, configuration registers, period, multiply and divide datapath
module epsm_datapath #(
  parameter int NUM_CHANNELS = 2,
  parameter int TIME_BITS    = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  input  epsm_pkg::epsm_cmd_t             cmd,
  output epsm_pkg::epsm_stat_t            stat,
  input  logic                            in_kind,
  input  logic                            in_channel,
  input  logic [47:0]                     in_time_us,
  input  logic                            in_direction_level,
  input  logic                            cfg_write,
  input  logic [epsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [epsm_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_channel,
  output logic [epsm_pkg::SPEED_W-1:0]    revs_per_sec,
  output logic [epsm_pkg::SPEED_W-1:0]    angular_velocity,
  output logic [epsm_pkg::SPEED_W-1:0]    linear_velocity,
  output logic                            stopped
);
  import epsm_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [TIMEOUT_W-1:0] timeout_us;
  logic [PPR_W-1:0]     pulses_per_rev_x100;
  logic [RADIUS_W-1:0]  radius_mm;

  logic                 item_kind;
  logic                 item_ch;
  logic [TIME_BITS-1:0] item_time;
  logic                 item_dir;

  logic [TIME_BITS-1:0] last_edge_time [NUM_CHANNELS];
  logic [PERIOD_W-1:0]  edge_period    [NUM_CHANNELS];
  logic                 reverse_flag   [NUM_CHANNELS];

  logic [CH_W-1:0]      ch_idx;
  logic [TIME_BITS-1:0] elapsed;
  logic [PERIOD_W-1:0]  period_sat;
  logic [PERIOD_W-1:0]  period;
  logic [DEN_W-1:0]     den_prod;
  logic [DEN_W-1:0]     den;
  logic [NUM_W-1:0]     vel_prod;
  logic [NUM_W-1:0]     vel_num;
  logic                 neg;

  logic                 rps_busy;
  logic                 ang_busy;
  logic                 vel_busy;
  logic [QUOT_W-1:0]    rps_mag;
  logic [QUOT_W-1:0]    ang_mag;
  logic [QUOT_W-1:0]    vel_mag;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_us          <= TIMEOUT_RST;
      pulses_per_rev_x100 <= PPR_RST;
      radius_mm           <= RADIUS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TIMEOUT: timeout_us          <= cfg_data[TIMEOUT_W-1:0];
        REG_PPR:     pulses_per_rev_x100 <= cfg_data[PPR_W-1:0];
        REG_RADIUS:  radius_mm           <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_kind <= in_kind;
      item_ch   <= in_channel;
      item_time <= TIME_BITS'(in_time_us);
      item_dir  <= in_direction_level;
    end
  end

  assign ch_idx = CH_W'(item_ch);

  // time since the channel's last edge, wrapping
  always_ff @(posedge clk) begin
    if (cmd.load_elapsed) begin
      elapsed <= item_time - last_edge_time[ch_idx];
    end
  end

  // per-channel edge state
  assign period_sat = ((elapsed >> 32) != '0) ? '1 : elapsed[PERIOD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        last_edge_time[i] <= '0;
        edge_period[i]    <= '0;
        reverse_flag[i]   <= 1'b0;
      end
    end else if (cmd.write_edge) begin
      last_edge_time[ch_idx] <= item_time;
      edge_period[ch_idx]    <= period_sat;
      reverse_flag[ch_idx]   <= item_dir;
    end
  end

  // status
  assign stat.chan_ok   = {31'b0, item_ch} < NUM_CHANNELS;
  assign stat.is_sample = item_kind;
  assign stat.timed_out = elapsed >= TIME_BITS'(timeout_us);
  assign stat.div_busy  = rps_busy | ang_busy | vel_busy;

  // effective period: stored period or the longer open interval
  always_ff @(posedge clk) begin
    if (cmd.load_period) begin
      period <= (elapsed > TIME_BITS'(edge_period[ch_idx])) ?
                elapsed[PERIOD_W-1:0] : edge_period[ch_idx];
    end
  end

  // denominator and linear numerator
  assign den_prod = period * pulses_per_rev_x100;
  assign vel_prod = VEL_NUM * radius_mm;

  always_ff @(posedge clk) begin
    if (cmd.load_operands) begin
      den     <= den_prod;
      vel_num <= vel_prod;
      neg     <= reverse_flag[ch_idx];
    end
  end

  // one divider per output, sharing the denominator
  epsm_div u_div_rps (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (RPS_NUM),
    .den   (den),
    .busy  (rps_busy),
    .mag   (rps_mag)
  );

  epsm_div u_div_ang (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (ANG_NUM),
    .den   (den),
    .busy  (ang_busy),
    .mag   (ang_mag)
  );

  epsm_div u_div_vel (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (vel_num),
    .den   (den),
    .busy  (vel_busy),
    .mag   (vel_mag)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_channel <= item_ch;
      stopped     <= cmd.result_stopped;
      if (cmd.result_stopped) begin
        revs_per_sec     <= '0;
        angular_velocity <= '0;
        linear_velocity  <= '0;
      end else begin
        revs_per_sec     <= neg ? (SPEED_W'(0) - {1'b0, rps_mag}) : {1'b0, rps_mag};
        angular_velocity <= neg ? (SPEED_W'(0) - {1'b0, ang_mag}) : {1'b0, ang_mag};
        linear_velocity  <= neg ? (SPEED_W'(0) - {1'b0, vel_mag}) : {1'b0, vel_mag};
      end
    end
  end

endmodule

// File: rtl/epsm_ctrl.sv
// sequencing state machine and result valid flag
module epsm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  epsm_pkg::epsm_stat_t stat,
  output epsm_pkg::epsm_cmd_t  cmd
);
  import epsm_pkg::*;

  epsm_state_t state;
  epsm_state_t state_next;
  logic        slot_free;

  assign slot_free = !out_valid || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state) inside
      ST_IDLE: begin
        if (in_valid) state_next = ST_ELAPSED;
      end
      ST_ELAPSED: state_next = ST_CHECK;
      ST_CHECK: begin
        if (!stat.chan_ok || !stat.is_sample) begin
          state_next = ST_IDLE;
        end else if (stat.timed_out) begin
          state_next = ST_OUT_STOP;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:      state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: state_next = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (!stat.div_busy) state_next = ST_OUT_SPEED;
      end
      ST_OUT_STOP, ST_OUT_SPEED: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_ELAPSED: cmd.load_elapsed = 1'b1;
      ST_CHECK: begin
        cmd.write_edge  = stat.chan_ok && !stat.is_sample;
        cmd.load_period = 1'b1;
      end
      ST_MUL:      cmd.load_operands = 1'b1;
      ST_DIV_LOAD: cmd.div_start     = 1'b1;
      ST_DIV_RUN:  ;
      ST_OUT_STOP: begin
        cmd.load_result    = slot_free;
        cmd.result_stopped = 1'b1;
      end
      ST_OUT_SPEED: cmd.load_result = slot_free;
      default: ;
    endcase
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/encoder_period_speed_meter_top.sv
// Encoder period speed meter: an edge item (tuser 0) records the period since the
// channel's previous edge, the edge time and the direction; a sample item (tuser 1)
// returns one result with revolutions per second and radians per second in Q16.16
// and millimetres per second in Q24.8, saturated at +/-0x7FFFFFFF, or zeros with
// the stopped flag when no edge came within timeout_us. A measured sample is
// divided by the three 31-step shift-subtract dividers that run side by side.
// One item is in work at a time; a finished result waits in the output
// register while the next item is taken. Configuration writes are always
// accepted and must be made while the block is idle.
module encoder_period_speed_meter_top #(
  parameter int NUM_CHANNELS = 2,
  parameter int TIME_BITS    = 48
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // channel [0], time_us [48:1], direction_level [49], zero [55:50]
  input  logic [epsm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // kind [0]
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_channel [0], revs_per_sec [32:1], angular_velocity [64:33],
  // linear_velocity [96:65], zero [103:97]
  output logic [epsm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // stopped [0]
  output logic                             m_axis_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [epsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [epsm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import epsm_pkg::*;

  epsm_cmd_t            cmd;
  epsm_stat_t           stat;
  logic                 out_channel;
  logic [SPEED_W-1:0]   revs_per_sec;
  logic [SPEED_W-1:0]   angular_velocity;
  logic [SPEED_W-1:0]   linear_velocity;
  logic                 stopped;

  assign cfg_ready = 1'b1;

  // controller
  epsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  epsm_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .TIME_BITS    (TIME_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .in_kind            (s_axis_tuser),
    .in_channel         (s_axis_tdata[0]),
    .in_time_us         (s_axis_tdata[48:1]),
    .in_direction_level (s_axis_tdata[49]),
    .cfg_write          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_channel        (out_channel),
    .revs_per_sec       (revs_per_sec),
    .angular_velocity   (angular_velocity),
    .linear_velocity    (linear_velocity),
    .stopped            (stopped)
  );

  // result packing
  assign m_axis_tdata = {7'b0, linear_velocity, angular_velocity, revs_per_sec, out_channel};
  assign m_axis_tuser = stopped;

endmodule
